// File: rtl/otsu_pkg.sv
// Shared constants for the Otsu threshold engine.
package otsu_pkg;

  localparam int LEVELS_DEF          = 256;
  localparam int MAX_PIXELS_LOG2_DEF = 24;
  localparam int PIXEL_W             = 8;
  localparam int THRESH_W            = 8;
  localparam int CMD_DEPTH           = 4;

endpackage

// File: rtl/otsu_front.sv
// Input stage: clamps levels, applies the pixel cap and keeps the running count and sum.
module otsu_front #(
  parameter int LEVELS          = otsu_pkg::LEVELS_DEF,
  parameter int MAX_PIXELS_LOG2 = otsu_pkg::MAX_PIXELS_LOG2_DEF,
  parameter int LW              = $clog2(LEVELS),
  parameter int CW              = MAX_PIXELS_LOG2 + 1,
  parameter int SW              = MAX_PIXELS_LOG2 + LW,
  parameter int CMD_W           = 2 + LW + CW + SW
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [otsu_pkg::PIXEL_W-1:0] pixel_value,
  input  logic                         last,
  input  logic                         push,
  output logic                         full,
  output logic                         q_push,
  output logic [CMD_W-1:0]             q_data,
  input  logic                         q_full
);
  import otsu_pkg::*;

  logic [CW-1:0] seen;
  logic [SW-1:0] sum;
  logic [CW-1:0] seen_next;
  logic [SW-1:0] sum_next;
  logic [LW-1:0] level;
  logic          inc;

  always_comb begin
    if ({1'b0, pixel_value} >= (PIXEL_W+1)'(LEVELS)) begin
      level = LW'(LEVELS - 1);
    end else begin
      level = pixel_value[LW-1:0];
    end
    inc       = ~seen[MAX_PIXELS_LOG2];
    seen_next = seen + CW'(inc);
    sum_next  = inc ? sum + SW'(level) : sum;
  end

  assign full   = q_full;
  assign q_push = push & ~q_full;
  assign q_data = {last, inc, level, seen_next, sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      sum  <= '0;
    end else if (q_push) begin
      if (last) begin
        seen <= '0;
        sum  <= '0;
      end else begin
        seen <= seen_next;
        sum  <= sum_next;
      end
    end
  end

endmodule

// File: rtl/otsu_fifo.sv
// Small command queue between the input stage and the histogram/scan engine.
module otsu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = otsu_pkg::CMD_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  import otsu_pkg::*;

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CNTW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/otsu_back.sv
// Histogram memory, per-image threshold scan with a serial multiplier, and result register.
module otsu_back #(
  parameter int LEVELS          = otsu_pkg::LEVELS_DEF,
  parameter int MAX_PIXELS_LOG2 = otsu_pkg::MAX_PIXELS_LOG2_DEF,
  parameter int LW              = $clog2(LEVELS),
  parameter int CW              = MAX_PIXELS_LOG2 + 1,
  parameter int SW              = MAX_PIXELS_LOG2 + LW,
  parameter int CMD_W           = 2 + LW + CW + SW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [CMD_W-1:0]              cmd_data,
  input  logic                          cmd_empty,
  output logic                          cmd_pop,
  output logic [otsu_pkg::THRESH_W-1:0] threshold,
  output logic [CW-1:0]                 pixel_count,
  output logic                          empty,
  input  logic                          pop
);
  import otsu_pkg::*;

  localparam int AW = SW + CW;
  localparam int NW = 2 * AW;
  localparam int DW = 2 * CW;
  localparam int PW = NW + DW;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_DRAIN, ST_READ, ST_ACC, ST_CHK, ST_MAG, ST_SQ, ST_LHS, ST_RHS, ST_DONE
  } state_t;

  state_t state;

  logic [CW-1:0] mem [LEVELS];
  logic [CW-1:0] rdata;
  logic          mem_we;
  logic [LW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;
  logic          mem_re;
  logic [LW-1:0] mem_raddr;

  logic          cmd_last;
  logic          cmd_inc;
  logic [LW-1:0] cmd_level;
  logic [CW-1:0] cmd_n;
  logic [SW-1:0] cmd_s;

  logic          p1_valid;
  logic [LW-1:0] p1_addr;
  logic          lw_valid;
  logic [LW-1:0] lw_addr;
  logic [CW-1:0] lw_data;
  logic [CW-1:0] cur;

  logic [LW-1:0]    t;
  logic [CW-1:0]    scan_n;
  logic [SW-1:0]    scan_s;
  logic [CW-1:0]    c0;
  logic [SW-1:0]    s0;
  logic [CW-1:0]    nmc;
  logic [AW-1:0]    a;
  logic [AW-1:0]    b;
  logic [AW-1:0]    mag;
  logic [DW-1:0]    den;
  logic [NW-1:0]    num;
  logic [PW-1:0]    lhs;
  logic [NW-1:0]    best_num;
  logic [DW-1:0]    best_den;
  logic [LW-1:0]    best;
  logic [PW-1:0]    mul_a;
  logic [AW-1:0]    mul_b;
  logic [PW-1:0]    acc;
  logic [LW+CW-1:0] tprod;

  logic                res_valid;
  logic [LW-1:0]       res_thr;
  logic [CW-1:0]       res_cnt;

  assign {cmd_last, cmd_inc, cmd_level, cmd_n, cmd_s} = cmd_data;
  assign cmd_pop = (state == ST_IDLE) && !cmd_empty;

  assign cur   = (lw_valid && lw_addr == p1_addr) ? lw_data : rdata;
  assign tprod = {{CW{1'b0}}, t} * {{LW{1'b0}}, rdata};
  assign mag   = (a > b) ? a - b : b - a;

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = t;
    mem_we    = 1'b0;
    mem_waddr = t;
    mem_wdata = '0;
    if (cmd_pop) begin
      mem_re    = 1'b1;
      mem_raddr = cmd_level;
    end else if (state == ST_READ) begin
      mem_re = 1'b1;
    end
    if (p1_valid) begin
      mem_we    = 1'b1;
      mem_waddr = p1_addr;
      mem_wdata = cur + 1'b1;
    end else if (state == ST_READ || state == ST_CLR) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      t         <= '0;
      p1_valid  <= 1'b0;
      lw_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      p1_valid <= cmd_pop & cmd_inc;
      p1_addr  <= cmd_level;
      lw_valid <= p1_valid;
      lw_addr  <= p1_addr;
      lw_data  <= cur + 1'b1;
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          if (t == LW'(LEVELS - 1)) begin
            t     <= '0;
            state <= ST_IDLE;
          end else begin
            t <= t + 1'b1;
          end
        end
        ST_IDLE: begin
          if (cmd_pop && cmd_last) begin
            scan_n <= cmd_n;
            scan_s <= cmd_s;
            state  <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          t        <= '0;
          c0       <= '0;
          s0       <= '0;
          best     <= '0;
          best_num <= '0;
          best_den <= DW'(1);
          state    <= ST_READ;
        end
        ST_READ: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          c0    <= c0 + rdata;
          s0    <= s0 + tprod[SW-1:0];
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (c0 == '0 || c0 >= scan_n) begin
            if (t == LW'(LEVELS - 1)) begin
              state <= ST_DONE;
            end else begin
              t     <= t + 1'b1;
              state <= ST_READ;
            end
          end else begin
            a     <= AW'(s0) * AW'(scan_n);
            b     <= AW'(scan_s) * AW'(c0);
            nmc   <= scan_n - c0;
            state <= ST_MAG;
          end
        end
        ST_MAG: begin
          den   <= DW'(c0) * DW'(nmc);
          mul_a <= PW'(mag);
          mul_b <= mag;
          acc   <= '0;
          state <= ST_SQ;
        end
        ST_SQ, ST_LHS, ST_RHS: begin
          if (mul_b != '0) begin
            if (mul_b[0]) begin
              acc <= acc + mul_a;
            end
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end else begin
            acc <= '0;
            if (state == ST_SQ) begin
              num   <= acc[NW-1:0];
              mul_a <= acc;
              mul_b <= AW'(best_den);
              state <= ST_LHS;
            end else if (state == ST_LHS) begin
              lhs   <= acc;
              mul_a <= PW'(best_num);
              mul_b <= AW'(den);
              state <= ST_RHS;
            end else begin
              if (lhs > acc) begin
                best_num <= num;
                best_den <= den;
                best     <= t;
              end
              if (t == LW'(LEVELS - 1)) begin
                state <= ST_DONE;
              end else begin
                t     <= t + 1'b1;
                state <= ST_READ;
              end
            end
          end
        end
        ST_DONE: begin
          if (!res_valid) begin
            res_valid <= 1'b1;
            res_thr   <= best;
            res_cnt   <= scan_n;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign empty       = ~res_valid;
  assign threshold   = THRESH_W'(res_thr);
  assign pixel_count = res_cnt;

  a_incr_outside_scan: assert property (@(posedge clk) disable iff (rst)
    p1_valid |-> (state == ST_IDLE || state == ST_DRAIN))
    else $error("histogram increment during scan");

  a_drain_before_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && t == '0) |-> !p1_valid)
    else $error("scan started with increment in flight");

  a_class_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHK) |-> (c0 <= scan_n))
    else $error("cumulative count exceeds image count");

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !res_valid) |=> (res_valid && state == ST_IDLE))
    else $error("finished scan did not post result");

endmodule

// File: rtl/otsu_threshold_engine_unit.sv
// Otsu threshold engine: top level.
// Pixels enter through a queue-style port: pixel_value and last are taken when
// push is high and full is low. Each result (threshold, pixel_count) appears
// while empty is low and is taken when pop is high.
// The input stage clamps and counts one pixel per cycle, while the queue is not
// full, into a CMD_DEPTH-entry command queue; while idle, the back end updates
// the LEVELS-bin histogram memory at one pixel per cycle (read, then write with
// bypass of the previous write). On the last pixel the back end scans every
// level, reading and zeroing its bin. A level with an empty class passes through
// the read, accumulate and check states; any other level also passes the
// magnitude state and three runs of the serial shift-add unit, one per
// multiplier operand (mag, best_den, den), each running until its operand is zero.
// With an idle back end, the last pixel's command passes through the command
// queue and the drain state before the scan. The input keeps taking pixels of
// the next image until the command queue is full, then full stays high until
// the back end has posted the scan's result. A finished result waits in the
// output register; if pop is held low, the next scan completes but holds its
// result until the register is free. After reset the back end clears every
// histogram bin before it takes commands; pixels still fill the queue meanwhile.
module otsu_threshold_engine_unit #(
  parameter int LEVELS          = otsu_pkg::LEVELS_DEF,
  parameter int MAX_PIXELS_LOG2 = otsu_pkg::MAX_PIXELS_LOG2_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [otsu_pkg::PIXEL_W-1:0]  pixel_value,
  input  logic                          last,
  input  logic                          push,
  output logic                          full,
  output logic [otsu_pkg::THRESH_W-1:0] threshold,
  output logic [MAX_PIXELS_LOG2:0]      pixel_count,
  output logic                          empty,
  input  logic                          pop
);
  import otsu_pkg::*;

  localparam int LW    = $clog2(LEVELS);
  localparam int CW    = MAX_PIXELS_LOG2 + 1;
  localparam int SW    = MAX_PIXELS_LOG2 + LW;
  localparam int CMD_W = 2 + LW + CW + SW;

  logic             q_push;
  logic [CMD_W-1:0] q_wdata;
  logic             q_full;
  logic [CMD_W-1:0] q_rdata;
  logic             q_empty;
  logic             q_pop;

  otsu_front #(
    .LEVELS          (LEVELS),
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_value (pixel_value),
    .last        (last),
    .push        (push),
    .full        (full),
    .q_push      (q_push),
    .q_data      (q_wdata),
    .q_full      (q_full)
  );

  otsu_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  otsu_back #(
    .LEVELS          (LEVELS),
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_data    (q_rdata),
    .cmd_empty   (q_empty),
    .cmd_pop     (q_pop),
    .threshold   (threshold),
    .pixel_count (pixel_count),
    .empty       (empty),
    .pop         (pop)
  );

endmodule
